// ----- hdl/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the stream find-and-replace block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 64;
    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 3;
    localparam int REPL_MAX  = 16;
    localparam int REPL_IDX_W = 4;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PAT_LO = 3'd0,
        CFG_PAT_HI = 3'd1,
        CFG_PAT_LEN = 3'd2,
        CFG_REP_LO = 3'd3,
        CFG_REP_HI = 3'd4,
        CFG_REP_LEN = 3'd5
    } t_cfg_idx;

    // controller -> datapath
    typedef struct packed {
        logic load;         // capture input request
        logic append;       // push input byte into window
        logic shift_emit;   // emit window head and shift
        logic repl_emit;    // emit next replacement byte
        logic nl_emit;      // emit the captured newline
        logic clear_count;  // drop the matched window
        logic finish;       // release held byte as last of the run
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_is_nl;     // byte on the input port is a newline
        logic last_flag;    // captured request marked the stream end
        logic count_zero;
        logic need_shift;   // window is no longer a pattern prefix
        logic match;        // window holds the whole pattern
        logic repl_zero;
        logic repl_done;
        logic emit_ok;      // hold stage can take a byte
        logic hold_valid;
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- hdl/stream_find_replace_top.sv -----
// ----------------------------------------------------------------------------
// stream_find_replace_top
// Streaming find-and-replace over a byte stream.
// ----------------------------------------------------------------------------
// Bytes enter one request at a time. Bytes that may still start the configured
// pattern are held in a window; a full match is replaced by the configured
// replacement, anything else passes through unchanged. A newline or a request
// with tlast flushes the window. Results go out as a run per input request with
// tlast on its final byte (a request may produce no result). Result bytes go
// out through a single emit path, a hold stage and the output register, one
// byte per cycle while output backpressure does not stall them. Input is taken
// while the previous result still waits in the output register. Configuration
// writes are always accepted; pattern writes are dropped while bytes are
// pending in the window.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_find_replace_top import sfr_pkg::*; #(
    parameter int PATTERN_MAX = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,   // [7:0] in_byte
    input  wire logic                 s_axis_tlast,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [7:0]                m_axis_tdata,   // [7:0] out_byte
    output logic                      m_axis_tlast,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    assign o_cfg_ready = 1'b1;

    sfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sfr_datapath #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_byte   (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_byte  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a request is in progress");

    // an idle block never sits on a complete match
    a_no_idle_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_sts.match)
        else $error("window holds a full pattern while idle");

    // every run is closed before the next request
    a_hold_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !w_sts.hold_valid)
        else $error("held result byte left over while idle");

    // a finished request with a held byte sends it out as the run-closing byte
    a_last_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish && w_sts.hold_valid |=> m_axis_tvalid && m_axis_tlast)
        else $error("closing byte did not reach the output");

endmodule

`default_nettype wire

// ----- hdl/sfr_datapath.sv -----
// ----------------------------------------------------------------------------
// sfr_datapath
// Window shift register, configuration registers, prefix compare, hold stage
// and output register of the find-and-replace block.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_datapath import sfr_pkg::*; #(
    parameter int PATTERN_MAX = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_sts                   o_sts,
    input  wire logic [BYTE_W-1:0]    i_in_byte,
    input  wire logic                 i_in_last,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [BYTE_W-1:0]         o_out_byte,
    output logic                      o_out_last
);

    localparam int CW = $clog2(PATTERN_MAX + 1);
    localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [CFG_W-1:0] r_pat_lo, r_pat_hi, r_rep_lo, r_rep_hi;
    logic [LEN_W-1:0] r_pat_len, r_rep_len;

    logic [BYTE_W-1:0] r_win [PATTERN_MAX];
    logic [CW-1:0]     r_count;
    logic [REPL_IDX_W-1:0] r_idx;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_last;
    logic [BYTE_W-1:0] r_hold;
    logic              r_hold_v;
    logic              r_out_v;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;

    logic [2*CFG_W-1:0] pat_all, rep_all;
    logic [LEN_W-1:0]   plen_eff, rlen_eff, count5;
    logic               mismatch;
    logic               out_free, emit_ok, emit;
    logic [BYTE_W-1:0]  emit_byte;

    assign pat_all = {r_pat_hi, r_pat_lo};
    assign rep_all = {r_rep_hi, r_rep_lo};
    assign count5  = LEN_W'(r_count);

    always_comb begin
        if (r_pat_len == '0) begin
            plen_eff = LEN_W'(1);
        end else if (r_pat_len > LEN_W'(PATTERN_MAX)) begin
            plen_eff = LEN_W'(PATTERN_MAX);
        end else begin
            plen_eff = r_pat_len;
        end
    end

    assign rlen_eff = (r_rep_len > LEN_W'(REPL_MAX)) ? LEN_W'(REPL_MAX) : r_rep_len;

    // parallel compare of the live window entries against the pattern
    always_comb begin
        mismatch = 1'b0;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if ((CW'(i) < r_count) && (r_win[i] != pat_all[8*i +: 8])) begin
                mismatch = 1'b1;
            end
        end
    end

    assign out_free = !r_out_v || i_out_ready;
    assign emit_ok  = !r_hold_v || out_free;
    assign emit     = i_cmd.shift_emit || i_cmd.repl_emit || i_cmd.nl_emit;

    always_comb begin
        if (i_cmd.shift_emit) begin
            emit_byte = r_win[0];
        end else if (i_cmd.repl_emit) begin
            emit_byte = rep_all[8*r_idx +: 8];
        end else begin
            emit_byte = r_in_byte;
        end
    end

    always_comb begin
        o_sts.in_is_nl   = (i_in_byte == NEWLINE_BYTE);
        o_sts.last_flag  = r_last;
        o_sts.count_zero = (r_count == '0);
        o_sts.need_shift = (r_count != '0) && (mismatch || (count5 > plen_eff));
        o_sts.match      = (count5 == plen_eff);
        o_sts.repl_zero  = (rlen_eff == '0);
        o_sts.repl_done  = ((LEN_W'(r_idx) + LEN_W'(1)) == rlen_eff);
        o_sts.emit_ok    = emit_ok;
        o_sts.hold_valid = r_hold_v;
    end

    // configuration; pattern fields are frozen while bytes are pending
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo  <= '0;
            r_pat_hi  <= '0;
            r_pat_len <= LEN_W'(1);
            r_rep_lo  <= '0;
            r_rep_hi  <= '0;
            r_rep_len <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PAT_LO:  if (r_count == '0) r_pat_lo <= i_cfg_data;
                CFG_PAT_HI:  if (r_count == '0) r_pat_hi <= i_cfg_data;
                CFG_PAT_LEN: if (r_count == '0) r_pat_len <= i_cfg_data[LEN_W-1:0];
                CFG_REP_LO:  r_rep_lo <= i_cfg_data;
                CFG_REP_HI:  r_rep_hi <= i_cfg_data;
                CFG_REP_LEN: r_rep_len <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // control state: counts and valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_idx    <= '0;
            r_hold_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.repl_emit) begin
                r_idx <= r_idx + REPL_IDX_W'(1);
            end

            if (i_cmd.clear_count) begin
                r_count <= '0;
            end else if (i_cmd.append) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.shift_emit) begin
                r_count <= r_count - CW'(1);
            end

            if (emit) begin
                r_hold_v <= 1'b1;
            end else if (i_cmd.finish) begin
                r_hold_v <= 1'b0;
            end

            if ((emit || i_cmd.finish) && r_hold_v) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_byte <= i_in_byte;
            r_last    <= i_in_last;
        end
        if (i_cmd.append) begin
            r_win[r_count[IW-1:0]] <= i_in_byte;
        end else if (i_cmd.shift_emit) begin
            for (int i = 0; i < PATTERN_MAX - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
        end
        if (emit) begin
            r_hold <= emit_byte;
        end
        if ((emit || i_cmd.finish) && r_hold_v) begin
            r_out_byte <= r_hold;
            r_out_last <= i_cmd.finish;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

// ----- hdl/sfr_ctrl.sv -----
// ----------------------------------------------------------------------------
// sfr_ctrl
// Sequencer for one input request: append or flush, shift out mismatches,
// expand a match, flush at stream end, then close the run.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_ctrl import sfr_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_CHECK = 4'b0010,
        S_REPL  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_sts.in_is_nl) begin
                        n_state = S_FLUSH;
                    end else begin
                        o_cmd.append = 1'b1;
                        n_state      = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.need_shift) begin
                    o_cmd.shift_emit = i_sts.emit_ok;
                end else if (i_sts.match) begin
                    if (i_sts.repl_zero) begin
                        o_cmd.clear_count = 1'b1;
                    end else begin
                        n_state = S_REPL;
                    end
                end else if (i_sts.last_flag && !i_sts.count_zero) begin
                    o_cmd.shift_emit = i_sts.emit_ok;
                end else if (i_sts.emit_ok) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_REPL: begin
                if (i_sts.emit_ok) begin
                    o_cmd.repl_emit = 1'b1;
                    if (i_sts.repl_done) begin
                        o_cmd.clear_count = 1'b1;
                        n_state           = S_CHECK;
                    end
                end
            end
            S_FLUSH: begin
                // window drains first, then the newline itself
                if (i_sts.emit_ok) begin
                    if (!i_sts.count_zero) begin
                        o_cmd.shift_emit = 1'b1;
                    end else begin
                        o_cmd.nl_emit = 1'b1;
                        n_state       = S_CHECK;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for stream_find_replace_top. A behavioral model of the
// byte rewriter predicts each output run as requests are accepted; the output
// monitor checks every byte and its tlast in order. Stimulus is a short
// directed pass followed by random text built around the configured pattern,
// with random idle on both streams and one long output hold-off.
// ----------------------------------------------------------------------------

module tb_top import sfr_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_beat;

    localparam int PATTERN_MAX   = 16;
    localparam int MAX_RUN       = 16;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 34;

    // register indexes outside the map; writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [7:0]           in_data = '0;
    logic                 in_last = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [7:0]           out_data;
    logic                 out_last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    stream_find_replace_top #(
        .PATTERN_MAX(PATTERN_MAX)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(in_valid),
        .s_axis_tready(in_ready),
        .s_axis_tdata (in_data),
        .s_axis_tlast (in_last),
        .m_axis_tvalid(out_valid),
        .m_axis_tready(out_ready),
        .m_axis_tdata (out_data),
        .m_axis_tlast (out_last),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // rewriter model: register copies and the pending window
    // ------------------------------------------------------------------
    logic [63:0] pat_lo = '0;
    logic [63:0] pat_hi = '0;
    logic [4:0]  pat_len_reg = 5'd1;
    logic [63:0] rep_lo = '0;
    logic [63:0] rep_hi = '0;
    logic [4:0]  rep_len_reg = '0;
    logic [7:0]  win [PATTERN_MAX];
    int          win_cnt = 0;

    t_beat text_q[$];       // requests waiting to be driven
    t_beat rewritten_q[$];  // predicted output bytes, oldest first
    t_beat step_out[$];

    int    errors = 0;
    int    result_count = 0;
    int    cycle_count = 0;
    bit    src_burst = 1'b0;
    bit    sink_burst = 1'b0;
    bit    hold_arm = 1'b0;
    bit    hold_taken = 1'b0;
    int    hold_left = 0;
    int    src_gap = 0;
    int    sink_stall = 0;
    t_beat src_next;

    function automatic logic [7:0] lane(logic [63:0] lo, logic [63:0] hi, int i);
        return (i < 8) ? lo[i*8 +: 8] : hi[(i-8)*8 +: 8];
    endfunction

    function automatic int eff_pat_len();
        int l = pat_len_reg;
        if (l == 0) l = 1;
        if (l > PATTERN_MAX) l = PATTERN_MAX;
        return l;
    endfunction

    function automatic bit window_on_pattern();
        for (int i = 0; i < win_cnt; i++)
            if (win[i] != lane(pat_lo, pat_hi, i)) return 1'b0;
        return 1'b1;
    endfunction

    // a run holds at most MAX_RUN bytes; anything past that is lost
    function automatic void put_byte(logic [7:0] b);
        t_beat bt;
        bt.data = b;
        bt.last = 1'b0;
        if (step_out.size() < MAX_RUN) step_out.push_back(bt);
    endfunction

    function automatic void shift_head();
        put_byte(win[0]);
        for (int i = 1; i < win_cnt; i++) win[i-1] = win[i];
        win_cnt--;
    endfunction

    function automatic void rewrite_byte(logic [7:0] b, logic last);
        int plen;
        int rlen;
        plen = eff_pat_len();
        rlen = (rep_len_reg > 5'd16) ? 16 : int'(rep_len_reg);
        step_out.delete();
        if (b == NEWLINE_BYTE) begin
            while (win_cnt > 0) shift_head();
            put_byte(b);
        end else begin
            if (win_cnt < PATTERN_MAX) begin
                win[win_cnt] = b;
                win_cnt++;
            end else begin
                put_byte(b);
            end
            while (win_cnt > 0 && (win_cnt > plen || !window_on_pattern())) shift_head();
            if (win_cnt == plen) begin
                for (int i = 0; i < rlen; i++) put_byte(lane(rep_lo, rep_hi, i));
                win_cnt = 0;
            end
        end
        if (last)
            while (win_cnt > 0) shift_head();
        if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
        foreach (step_out[i]) rewritten_q.push_back(step_out[i]);
    endfunction

    // pattern registers are locked while bytes sit in the window
    function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        unique case (idx)
            CFG_PAT_LO:  if (win_cnt == 0) pat_lo = val;
            CFG_PAT_HI:  if (win_cnt == 0) pat_hi = val;
            CFG_PAT_LEN: if (win_cnt == 0) pat_len_reg = val[4:0];
            CFG_REP_LO:  rep_lo = val;
            CFG_REP_HI:  rep_hi = val;
            CFG_REP_LEN: rep_len_reg = val[4:0];
            default: ;
        endcase
    endfunction

    function automatic int idle_len(bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR: result %0d: %s", result_count, msg);
        errors++;
    endtask

    task automatic check_result(logic [7:0] data, logic last);
        t_beat want;
        if (rewritten_q.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %h last %b", data, last));
        end else begin
            want = rewritten_q.pop_front();
            if (data !== want.data)
                report_mismatch($sformatf("byte %h, expected %h", data, want.data));
            if (last !== want.last)
                report_mismatch($sformatf("tlast %b, expected %b", last, want.last));
        end
        result_count++;
    endtask

    // ------------------------------------------------------------------
    // input driver: model is stepped on each accepted request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) rewrite_byte(in_data, in_last);
            if (!in_valid || in_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    in_valid <= 1'b0;
                end else if (text_q.size() > 0) begin
                    src_next = text_q.pop_front();
                    in_data  <= src_next.data;
                    in_last  <= src_next.last;
                    in_valid <= 1'b1;
                    src_gap  = idle_len(src_burst);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output monitor and backpressure
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) check_result(out_data, out_last);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
            end else if (sink_burst) begin
                out_ready <= 1'b1;
            end else if (sink_stall > 0) begin
                sink_stall--;
                out_ready <= 1'b0;
            end else begin
                sink_stall = idle_len(1'b0);
                out_ready <= (sink_stall == 0);
            end
        end
    end

    // one long output hold-off, armed once by the sequence
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_arm && !hold_taken) begin
            hold_left  <= HOLD_CYCLES;
            hold_taken <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes outstanding",
                     cycle_count, rewritten_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_cfg(idx, val);
    endtask

    task automatic configure(logic [63:0] p_lo, logic [63:0] p_hi, logic [4:0] p_len,
                             logic [63:0] r_lo, logic [63:0] r_hi, logic [4:0] r_len);
        logic [63:0] len_word;
        cfg_write(CFG_PAT_LO, p_lo);
        cfg_write(CFG_PAT_HI, p_hi);
        len_word = {$urandom, $urandom};
        len_word[4:0] = p_len;
        cfg_write(CFG_PAT_LEN, len_word);
        cfg_write(CFG_REP_LO, r_lo);
        cfg_write(CFG_REP_HI, r_hi);
        len_word = {$urandom, $urandom};
        len_word[4:0] = r_len;
        cfg_write(CFG_REP_LEN, len_word);
    endtask

    task automatic push_byte(logic [7:0] b, logic last);
        t_beat bt;
        bt.data = b;
        bt.last = last;
        text_q.push_back(bt);
    endtask

    // text mostly built from whole and partial pattern copies
    task automatic push_text(int n_items, bit end_last);
        int cnt;
        int plen;
        int r;
        int k;
        cnt  = 0;
        plen = eff_pat_len();
        while (cnt < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                for (int i = 0; i < plen; i++) begin
                    push_byte(lane(pat_lo, pat_hi, i), $urandom_range(0, 99) < 3);
                    cnt++;
                end
            end else if (r < 55) begin
                k = (plen > 1) ? $urandom_range(1, plen - 1) : 1;
                for (int i = 0; i < k; i++) begin
                    push_byte(lane(pat_lo, pat_hi, i), $urandom_range(0, 99) < 3);
                    cnt++;
                end
            end else if (r < 70) begin
                push_byte(lane(pat_lo, pat_hi, $urandom_range(0, plen - 1)),
                          $urandom_range(0, 99) < 3);
                cnt++;
            end else if (r < 80) begin
                push_byte(NEWLINE_BYTE, $urandom_range(0, 99) < 3);
                cnt++;
            end else begin
                push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 3);
                cnt++;
            end
        end
        if (end_last) text_q[text_q.size()-1].last = 1'b1;
    endtask

    // all requests accepted, all predicted bytes seen, then let the block settle
    task automatic wait_idle();
        do @(negedge i_clk); while (text_q.size() != 0 || in_valid || rewritten_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [63:0] p_lo, p_hi, r_lo, r_hi;
        logic [4:0]  p_len, r_len;
        logic [7:0]  pb;
        int          nl_pos;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: a single zero byte pattern that deletes matches
        @(negedge i_clk);
        push_byte(8'h00, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(NEWLINE_BYTE, 1'b0);
        push_byte(8'hFF, 1'b1);
        wait_idle();

        // "abc" -> "XY"
        configure(64'h0000_0000_0063_6261, 64'h0, 5'd3,
                  64'h0000_0000_0000_5958, 64'h0, 5'd2);
        @(negedge i_clk);
        push_byte("a", 1'b0); push_byte("b", 1'b0); push_byte("c", 1'b0);
        // mismatch shift: "ababc"
        push_byte("a", 1'b0); push_byte("b", 1'b0); push_byte("a", 1'b0);
        push_byte("b", 1'b0); push_byte("c", 1'b0);
        // newline flushes a partial match
        push_byte("a", 1'b0); push_byte("b", 1'b0); push_byte(NEWLINE_BYTE, 1'b0);
        // stream end flushes a partial match
        push_byte("a", 1'b0); push_byte("b", 1'b1);
        // leave one byte pending for the locked pattern write
        push_byte("a", 1'b0);
        wait_idle();
        cfg_write(CFG_PAT_LO, 64'h0000_0000_007A_7A7A);
        cfg_write(CFG_REP_LEN, 64'd1);
        @(negedge i_clk);
        push_byte("b", 1'b0); push_byte("c", 1'b1);
        push_byte("a", 1'b0); push_byte(NEWLINE_BYTE, 1'b0);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       begin p_len = 5'd16; r_len = 5'd16; end
                1:       begin p_len = 5'd1;  r_len = 5'd0;  end
                2:       begin p_len = 5'd0;  r_len = 5'd31; end  // zero length pattern, oversize repl
                3:       begin p_len = 5'd31; r_len = 5'd17; end  // both lengths saturate
                4:       begin p_len = 5'd5;  r_len = 5'($urandom_range(0, 16)); end
                default: begin
                    p_len = 5'($urandom_range(1, 16));
                    r_len = 5'($urandom_range(0, 16));
                end
            endcase
            p_lo = '0;
            p_hi = '0;
            for (int i = 0; i < PATTERN_MAX; i++) begin
                pb = (p % 3 == 0) ? 8'($urandom_range(0, 255)) : 8'h61 + 8'($urandom_range(0, 2));
                if (i < 8) p_lo[i*8 +: 8] = pb;
                else p_hi[(i-8)*8 +: 8] = pb;
            end
            if (p == 4) begin
                // newline inside the pattern can never match
                nl_pos = 2;
                p_lo[nl_pos*8 +: 8] = NEWLINE_BYTE;
            end
            r_lo = {$urandom, $urandom};
            r_hi = {$urandom, $urandom};
            configure(p_lo, p_hi, p_len, r_lo, r_hi, r_len);
            if (p == 5) begin
                cfg_write(CFG_SPARE_LO, {$urandom, $urandom});
                cfg_write(CFG_SPARE_HI, {$urandom, $urandom});
            end

            @(negedge i_clk);
            src_burst  = ($urandom_range(0, 3) == 0);
            sink_burst = ($urandom_range(0, 3) == 0);
            if (p == 2) begin
                // sender keeps pushing while the output is held off
                src_burst  = 1'b1;
                sink_burst = 1'b0;
                hold_arm   = 1'b1;
            end
            push_text(PHASE_ITEMS, p % 4 != 3);
            wait_idle();
        end

        wait_idle();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- stream_find_replace_top.f -----
hdl/sfr_pkg.sv
hdl/sfr_datapath.sv
hdl/sfr_ctrl.sv
hdl/stream_find_replace_top.sv
tb/sv/tb_top.sv
